// File: hw/rtl/tuip_pkg.sv
// Shared types and constants of the text to unsigned integer parser.
`timescale 1ns / 1ps

package tuip_pkg;

    localparam int BASE_W      = 6;
    localparam int CHAR_W      = 8;
    localparam int DIGIT_W     = 6;
    localparam int OUT_VALUE_W = 32;
    localparam int OUT_COUNT_W = 16;
    localparam int QUEUE_DEPTH = 2;

    // Base codes.
    localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
    localparam logic [BASE_W-1:0] BASE_ONE  = 6'd1;
    localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
    localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
    localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;
    localparam logic [BASE_W-1:0] BASE_MAX  = 6'd36;

    // Digit value of a character that is neither a digit nor a letter.
    localparam logic [DIGIT_W-1:0] DIGIT_NONE = 6'd63;
    localparam logic [DIGIT_W-1:0] DIGIT_TEN  = 6'd10;

    // Character codes.
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
    localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;
    localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7A;

    // One classified character as it travels from front to back.
    typedef struct packed {
        logic               start;
        logic [BASE_W-1:0]  base;
        logic [DIGIT_W-1:0] digit;
        logic               space;
        logic               zero;
        logic               x_char;
    } item_t;

    // Fill status of the queue between front and back.
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// File: hw/rtl/tuip_front.sv
// Front end: accepts input transfers and classifies each character.
`timescale 1ns / 1ps

module tuip_front
    import tuip_pkg::*;
(
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_start_req,
    input  logic [BASE_W-1:0] s_requested_base,
    input  logic [CHAR_W-1:0] s_ch,
    input  q_status_t         q_status,
    output logic              push,
    output item_t             push_item
);

    logic [CHAR_W-1:0] num_off;
    logic [CHAR_W-1:0] low_off;
    logic [CHAR_W-1:0] up_off;

    assign s_ready = !q_status.full;
    assign push    = s_valid && !q_status.full;

    assign num_off = s_ch - CH_ZERO;
    assign low_off = s_ch - CH_LA + CHAR_W'(DIGIT_TEN);
    assign up_off  = s_ch - CH_UA + CHAR_W'(DIGIT_TEN);

    always_comb begin
        push_item.start  = s_start_req;
        push_item.base   = s_requested_base;
        push_item.space  = (s_ch == CH_SPACE) || ((s_ch >= CH_TAB) && (s_ch <= CH_CR));
        push_item.zero   = (s_ch == CH_ZERO);
        push_item.x_char = (s_ch == CH_LX) || (s_ch == CH_UX);
        if ((s_ch >= CH_ZERO) && (s_ch <= CH_NINE)) begin
            push_item.digit = num_off[DIGIT_W-1:0];
        end else if ((s_ch >= CH_LA) && (s_ch <= CH_LZ)) begin
            push_item.digit = low_off[DIGIT_W-1:0];
        end else if ((s_ch >= CH_UA) && (s_ch <= CH_UZ)) begin
            push_item.digit = up_off[DIGIT_W-1:0];
        end else begin
            push_item.digit = DIGIT_NONE;
        end
    end

endmodule

// File: hw/rtl/tuip_queue.sv
// Short queue of classified characters between front and back.
`timescale 1ns / 1ps

module tuip_queue
    import tuip_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  item_t     push_item,
    input  logic      pop,
    output item_t     pop_item,
    output q_status_t status
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t            mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign status.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign pop_item     = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: hw/rtl/tuip_back.sv
// Back end: parse state machine, multiply-add and output register.
`timescale 1ns / 1ps

module tuip_back
    import tuip_pkg::*;
#(
    parameter int VALUE_BITS = 32,
    parameter int COUNT_BITS = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    input  item_t                  in_item,
    output logic                   in_ready,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [OUT_VALUE_W-1:0] m_value,
    output logic                   m_done_res,
    output logic [OUT_COUNT_W-1:0] m_consumed
);

    typedef enum logic [2:0] {
        PH_SPACE  = 3'd0,
        PH_ZERO   = 3'd1,
        PH_PREFIX = 3'd2,
        PH_DIGITS = 3'd3,
        PH_DONE   = 3'd4
    } phase_t;

    phase_t                phase_reg, phase_next, ph_cur;
    logic [BASE_W-1:0]     base_reg, base_next, base_cur, mul_base;
    logic [VALUE_BITS-1:0] acc_reg, acc_next, acc_cur, mac;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next, cnt_cur, cnt_inc;
    logic [COUNT_BITS-1:0] pend_reg, pend_next, pend_cur;
    logic [VALUE_BITS+BASE_W-1:0] mac_full;
    logic [VALUE_BITS+OUT_VALUE_W-1:0] value_ext;
    logic [COUNT_BITS+OUT_COUNT_W-1:0] count_ext;
    logic                  digit_ok;
    logic                  done_next;
    logic                  fire;
    logic                  m_valid_reg;
    logic [OUT_VALUE_W-1:0] m_value_reg;
    logic                  m_done_reg;
    logic [OUT_COUNT_W-1:0] m_consumed_reg;

    assign in_ready   = !m_valid_reg || m_ready;
    assign fire       = in_valid && in_ready;
    assign m_valid    = m_valid_reg;
    assign m_value    = m_value_reg;
    assign m_done_res = m_done_reg;
    assign m_consumed = m_consumed_reg;

    // A start item sees freshly cleared state with the requested base.
    assign ph_cur   = in_item.start ? PH_SPACE : phase_reg;
    assign base_cur = in_item.start ? in_item.base : base_reg;
    assign acc_cur  = in_item.start ? '0 : acc_reg;
    assign cnt_cur  = in_item.start ? '0 : cnt_reg;
    assign pend_cur = in_item.start ? '0 : pend_reg;

    // Automatic base resolves to decimal on a first nonzero digit and to
    // octal after a leading zero without an x.
    always_comb begin
        mul_base = base_cur;
        if ((ph_cur == PH_SPACE) && (base_cur == BASE_AUTO)) begin
            mul_base = BASE_DEC;
        end else if ((ph_cur == PH_ZERO) && (base_cur == BASE_AUTO)) begin
            mul_base = BASE_OCT;
        end
    end

    assign digit_ok = (in_item.digit < mul_base);
    assign mac_full = {{BASE_W{1'b0}}, acc_cur} * {{VALUE_BITS{1'b0}}, mul_base}
                    + {{VALUE_BITS{1'b0}}, in_item.digit};
    assign mac      = mac_full[VALUE_BITS-1:0];
    assign cnt_inc  = (cnt_cur == '1) ? cnt_cur : cnt_cur + 1'b1;

    always_comb begin
        phase_next = ph_cur;
        base_next  = base_cur;
        acc_next   = acc_cur;
        cnt_next   = cnt_cur;
        pend_next  = pend_cur;
        done_next  = 1'b0;
        unique case (ph_cur)
            PH_SPACE: begin
                if (in_item.space) begin
                    cnt_next = cnt_inc;
                end else if ((base_cur == BASE_ONE) || (base_cur > BASE_MAX)) begin
                    acc_next   = '0;
                    cnt_next   = '0;
                    phase_next = PH_DONE;
                    done_next  = 1'b1;
                end else if (in_item.zero &&
                             ((base_cur == BASE_AUTO) || (base_cur == BASE_HEX))) begin
                    acc_next   = '0;
                    cnt_next   = cnt_inc;
                    pend_next  = cnt_inc;
                    phase_next = PH_ZERO;
                end else begin
                    base_next = mul_base;
                    if (digit_ok) begin
                        acc_next   = mac;
                        cnt_next   = cnt_inc;
                        phase_next = PH_DIGITS;
                    end else begin
                        acc_next   = '0;
                        cnt_next   = '0;
                        phase_next = PH_DONE;
                        done_next  = 1'b1;
                    end
                end
            end
            PH_ZERO: begin
                if (in_item.x_char) begin
                    base_next  = BASE_HEX;
                    cnt_next   = cnt_inc;
                    phase_next = PH_PREFIX;
                end else begin
                    base_next = mul_base;
                    if (digit_ok) begin
                        acc_next   = mac;
                        cnt_next   = cnt_inc;
                        phase_next = PH_DIGITS;
                    end else begin
                        phase_next = PH_DONE;
                        done_next  = 1'b1;
                    end
                end
            end
            PH_PREFIX: begin
                if (digit_ok) begin
                    acc_next   = mac;
                    cnt_next   = cnt_inc;
                    phase_next = PH_DIGITS;
                end else begin
                    acc_next   = '0;
                    cnt_next   = pend_cur;
                    phase_next = PH_DONE;
                    done_next  = 1'b1;
                end
            end
            PH_DIGITS: begin
                if (digit_ok) begin
                    acc_next = mac;
                    cnt_next = cnt_inc;
                end else begin
                    phase_next = PH_DONE;
                    done_next  = 1'b1;
                end
            end
            PH_DONE: begin
            end
            default: begin
            end
        endcase
    end

    assign value_ext = {{OUT_VALUE_W{1'b0}}, acc_next};
    assign count_ext = {{OUT_COUNT_W{1'b0}}, cnt_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_SPACE;
            base_reg    <= BASE_AUTO;
            acc_reg     <= '0;
            cnt_reg     <= '0;
            pend_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (fire) begin
                phase_reg      <= phase_next;
                base_reg       <= base_next;
                acc_reg        <= acc_next;
                cnt_reg        <= cnt_next;
                pend_reg       <= pend_next;
                m_value_reg    <= value_ext[OUT_VALUE_W-1:0];
                m_done_reg     <= done_next;
                m_consumed_reg <= count_ext[OUT_COUNT_W-1:0];
            end
            m_valid_reg <= fire || (m_valid_reg && !m_ready);
        end
    end

endmodule

// File: hw/rtl/text_to_unsigned_integer_parser.sv
// Top level of the streaming text to unsigned integer parser.
`timescale 1ns / 1ps

// Streaming parser that turns a character string into an unsigned number,
// one byte per input transfer, in the manner of the C library routine that
// converts text to an unsigned long. A transfer with s_start_req set opens a
// new string and brings the base (2 to 36, or 0 to detect it from a "0x" or
// leading "0" prefix). Leading whitespace is skipped, digits and letters
// below the base accumulate modulo 2^VALUE_BITS, and the first character that
// is not a valid digit ends the number. Every input transfer yields exactly
// one result transfer: m_value is the number so far, m_consumed the count of
// characters taken (on the ending character, the end position a pointer
// would give), and m_done_res marks the character that ended the number.
// Characters after the end and before the next start return the held result.
// The block sustains one character per clock while the output is not
// stalled: the front classifies the byte, a two-entry queue decouples it
// from the back, and the back does one multiply-add per cycle into a
// registered output, so a result passes through the queue and then the
// output register before it can be taken.
module text_to_unsigned_integer_parser
    import tuip_pkg::*;
#(
    parameter int VALUE_BITS = 32,
    parameter int COUNT_BITS = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_start_req,
    input  logic [BASE_W-1:0]      s_requested_base,
    input  logic [CHAR_W-1:0]      s_ch,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [OUT_VALUE_W-1:0] m_value,
    output logic                   m_done_res,
    output logic [OUT_COUNT_W-1:0] m_consumed
);

    // Front to queue.
    logic      push;
    item_t     push_item;
    q_status_t q_status;

    // Queue to back.
    logic  pop;
    item_t pop_item;
    logic  back_ready;

    tuip_front u_front (
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_start_req      (s_start_req),
        .s_requested_base (s_requested_base),
        .s_ch             (s_ch),
        .q_status         (q_status),
        .push             (push),
        .push_item        (push_item)
    );

    tuip_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .status    (q_status)
    );

    // The back takes the queue head whenever its output register is free
    // or is being emptied in the same cycle.
    assign pop = !q_status.empty && back_ready;

    tuip_back #(
        .VALUE_BITS (VALUE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (!q_status.empty),
        .in_item    (pop_item),
        .in_ready   (back_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_value    (m_value),
        .m_done_res (m_done_res),
        .m_consumed (m_consumed)
    );

    // The queue can never be both full and empty.
    a_queue_status: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_status.full && q_status.empty))
        else $error("queue reports full and empty at once");

    // An accepted input transfer is held either in the queue or in the output.
    a_transfer_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && $past(s_valid && s_ready)) |-> (!q_status.empty || m_valid))
        else $error("accepted transfer lost between front and back");

    // With work queued and a free output register, the back produces a result.
    a_back_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (!q_status.empty && !m_valid) |=> m_valid)
        else $error("back stalled with queued work and a free output");

endmodule

// File: bench/tb_top.sv
// Self-checking testbench of the streaming text to unsigned integer parser.
`timescale 1ns / 1ps

// The bench drives character transfers into the parser and checks each result
// transfer against a behavioral parser kept inside the bench.
//
// The bench runs in two parts:
//   - A directed table walks through the corner cases:
//       - parsing with no start since reset;
//       - skipped whitespace;
//       - the hex prefix, and the hex prefix with no hex digit behind it;
//       - automatic octal;
//       - base 36 with letters of both cases;
//       - an invalid base;
//       - a string with no digits, and the smallest base;
//       - characters that arrive after the number has ended.
//     Rows whose result is obvious carry a typed-in expectation. The other
//     rows use the behavioral parser.
//   - Random strings follow. Each has a random base, leading whitespace, an
//     optional prefix, digits legal for the base (decimal for an invalid base),
//     mostly a terminator and some trailing characters. Noise strings mix in.
//
// Handshake timing:
//   - Inputs change on the falling edge of aclk.
//   - Both channels are sampled on the rising edge.
//   - The sender works in random bursts.
//   - The receiver stalls in modes of its own.
//   - Twice, the receiver holds off long enough to back the parser up.
module tb_top;
    import tuip_pkg::*;

    localparam int RANDOM_ITEMS     = 1025;
    localparam int LONG_HOLD_CYCLES = 60;
    localparam int TAIL_CYCLES      = 10;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int NOT_A_DIGIT      = 99;
    localparam int N_DIRECTED       = 26;

    localparam logic [CHAR_W-1:0] CH_NUL  = 8'h00;
    localparam logic [CHAR_W-1:0] CH_DASH = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_TOP  = 8'hFF;

    // Parse phases of the behavioral parser.
    typedef enum logic [2:0] {
        PH_SKIP_SPACE,
        PH_SAW_ZERO,
        PH_SAW_PREFIX,
        PH_IN_DIGITS,
        PH_FINISHED
    } parse_phase_t;

    // One result transfer as the parser reports it.
    typedef struct packed {
        logic [OUT_VALUE_W-1:0] value;
        logic                   done;
        logic [OUT_COUNT_W-1:0] consumed;
    } parse_result_t;

    // One row of the directed table. If pinned is set, want is the result
    // typed in by hand. Otherwise the behavioral parser supplies it.
    typedef struct packed {
        logic              opens;
        logic [BASE_W-1:0] base;
        logic [CHAR_W-1:0] ch;
        logic              pinned;
        parse_result_t     want;
    } char_row_t;

    localparam parse_result_t NO_PIN = '0;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic                   s_start_req = 1'b0;
    logic [BASE_W-1:0]      s_requested_base = BASE_AUTO;
    logic [CHAR_W-1:0]      s_ch = CH_NUL;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [OUT_VALUE_W-1:0] m_value;
    logic                   m_done_res;
    logic [OUT_COUNT_W-1:0] m_consumed;

    // A pinned expectation travels with the character it belongs to.
    logic                   pin_valid = 1'b0;
    parse_result_t          pin_result = '0;

    // Behavioral parser state.
    parse_phase_t           ps_phase = PH_SKIP_SPACE;
    logic [BASE_W-1:0]      ps_base = BASE_AUTO;
    logic [OUT_VALUE_W-1:0] ps_acc = '0;
    logic [OUT_COUNT_W-1:0] ps_count = '0;
    logic [OUT_COUNT_W-1:0] ps_zero_count = '0;

    parse_result_t awaited_results[$];
    int            mismatch_count = 0;
    int            idle_cycles = 0;
    int            burst_left = 0;
    bit            hold_request = 1'b0;
    char_row_t     directed_rows[N_DIRECTED];

    text_to_unsigned_integer_parser DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_start_req     (s_start_req),
        .s_requested_base(s_requested_base),
        .s_ch            (s_ch),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_value         (m_value),
        .m_done_res      (m_done_res),
        .m_consumed      (m_consumed)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Returns the digit value of a character, for digits and letters of
    // either case, or NOT_A_DIGIT for anything else.
    function automatic int digit_value(input logic [CHAR_W-1:0] c);
        if (c >= CH_ZERO && c <= CH_NINE) return int'(c) - int'(CH_ZERO);
        if (c >= CH_LA && c <= CH_LZ) return int'(c) - int'(CH_LA) + int'(DIGIT_TEN);
        if (c >= CH_UA && c <= CH_UZ) return int'(c) - int'(CH_UA) + int'(DIGIT_TEN);
        return NOT_A_DIGIT;
    endfunction

    // Whitespace is a space or one of the characters from TAB to CR.
    function automatic logic is_blank(input logic [CHAR_W-1:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    // The character count saturates instead of wrapping.
    function automatic void bump_count();
        if (ps_count != '1) ps_count++;
    endfunction

    function automatic void finish_at(input logic [OUT_VALUE_W-1:0] v,
                                      input logic [OUT_COUNT_W-1:0] n);
        ps_acc   = v;
        ps_count = n;
        ps_phase = PH_FINISHED;
    endfunction

    // Accumulates a digit that lies below the active base. Any other
    // character ends the number where it stands. Returns 1 on the end.
    function automatic logic take_digit(input logic [CHAR_W-1:0] c);
        int d;
        d = digit_value(c);
        if (d < int'(ps_base)) begin
            ps_acc   = ps_acc * ps_base + OUT_VALUE_W'(d);
            ps_phase = PH_IN_DIGITS;
            bump_count();
            return 1'b0;
        end
        ps_phase = PH_FINISHED;
        return 1'b1;
    endfunction

    // Advances the behavioral parser by one accepted character and returns
    // the result transfer that this character should produce.
    function automatic parse_result_t parse_char(input logic opens,
                                                 input logic [BASE_W-1:0] base_in,
                                                 input logic [CHAR_W-1:0] c);
        logic          done;
        parse_result_t r;
        done = 1'b0;
        if (opens) begin
            ps_phase      = PH_SKIP_SPACE;
            ps_acc        = '0;
            ps_count      = '0;
            ps_zero_count = '0;
            ps_base       = base_in;
        end
        case (ps_phase)
            PH_SKIP_SPACE: begin
                if (is_blank(c)) begin
                    bump_count();
                end else if (ps_base == BASE_ONE || ps_base > BASE_MAX) begin
                    finish_at('0, '0);
                    done = 1'b1;
                end else if (c == CH_ZERO && (ps_base == BASE_AUTO || ps_base == BASE_HEX)) begin
                    // A leading zero may open a hex prefix, so its count is
                    // kept as the end position in case no hex digit follows.
                    ps_acc = '0;
                    bump_count();
                    ps_zero_count = ps_count;
                    ps_phase = PH_SAW_ZERO;
                end else begin
                    if (ps_base == BASE_AUTO) ps_base = BASE_DEC;
                    if (digit_value(c) < int'(ps_base)) begin
                        void'(take_digit(c));
                    end else begin
                        finish_at('0, '0);
                        done = 1'b1;
                    end
                end
            end
            PH_SAW_ZERO: begin
                if (c == CH_LX || c == CH_UX) begin
                    ps_base = BASE_HEX;
                    bump_count();
                    ps_phase = PH_SAW_PREFIX;
                end else begin
                    if (ps_base == BASE_AUTO) ps_base = BASE_OCT;
                    done = take_digit(c);
                end
            end
            PH_SAW_PREFIX: begin
                // With no hex digit after the prefix, the number ends just
                // after the zero.
                if (digit_value(c) < int'(BASE_HEX)) begin
                    void'(take_digit(c));
                end else begin
                    finish_at('0, ps_zero_count);
                    done = 1'b1;
                end
            end
            PH_IN_DIGITS: done = take_digit(c);
            default: ;
        endcase
        r.value    = ps_acc;
        r.done     = done;
        r.consumed = ps_count;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        mismatch_count++;
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h",
                 $realtime, what, got, want);
    endtask

    // On every rising edge, an accepted result is compared with the oldest
    // expectation, and an accepted character pushes a new expectation. The
    // result is checked first. It can never belong to a character accepted
    // on the same edge.
    always @(posedge aclk) begin : result_compare
        parse_result_t got;
        parse_result_t want;
        if (!aresetn) begin
            idle_cycles = 0;
        end else begin
            if (m_valid && m_ready) begin
                got.value    = m_value;
                got.done     = m_done_res;
                got.consumed = m_consumed;
                if (awaited_results.size() == 0) begin
                    report_mismatch("result with no character pending", got, 0);
                end else begin
                    want = awaited_results.pop_front();
                    if (got.value !== want.value)
                        report_mismatch("m_value", got.value, want.value);
                    if (got.done !== want.done)
                        report_mismatch("m_done_res", got.done, want.done);
                    if (got.consumed !== want.consumed)
                        report_mismatch("m_consumed", got.consumed, want.consumed);
                end
            end
            if (s_valid && s_ready) begin
                want = parse_char(s_start_req, s_requested_base, s_ch);
                if (pin_valid) want = pin_result;
                awaited_results.push_back(want);
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
        end
    end

    // A run with no transfer on either channel for too long has hung.
    initial begin : hang_guard
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("** text_to_unsigned_integer_parser: FAILED **");
        $finish;
    end

    // The receiver stalls in modes that change at random:
    //   - always ready;
    //   - coin flips;
    //   - ready one cycle in four;
    //   - mostly ready.
    // A hold request from the stimulus drops ready for a long stretch. The
    // parser then fills up and must stall its input.
    initial begin : result_sink
        int mode;
        int mode_left;
        int tick;
        mode = 0;
        mode_left = 0;
        tick = 0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge aclk);
                hold_request = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 80);
                end
                mode_left--;
                tick++;
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(0, 1));
                    2: m_ready <= (tick % 4 == 0);
                    default: m_ready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    // Offers one character and returns on the falling edge after the
    // transfer. When a burst runs out, valid may drop for a random gap first.
    // The call starts and ends on a falling edge, so valid gets one update
    // per step.
    task automatic send_char(input logic opens, input logic [BASE_W-1:0] base_in,
                             input logic [CHAR_W-1:0] c, input logic pinned,
                             input parse_result_t pinned_result);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_valid          <= 1'b1;
        s_start_req      <= opens;
        s_requested_base <= base_in;
        s_ch             <= c;
        pin_valid        <= pinned;
        pin_result       <= pinned_result;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Sends a character without a start. The base field is ignored there, so
    // it carries random bits.
    task automatic send_plain(input logic [CHAR_W-1:0] c);
        send_char(1'b0, BASE_W'($urandom_range(0, 36)), c, 1'b0, NO_PIN);
    endtask

    // Drops valid and waits until every expected result has arrived.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (awaited_results.size() != 0) @(negedge aclk);
    endtask

    function automatic logic [CHAR_W-1:0] random_blank();
        if ($urandom_range(0, 6) == 0) return CH_SPACE;
        return CH_TAB + CHAR_W'($urandom_range(0, 4));
    endfunction

    function automatic logic [CHAR_W-1:0] digit_char(input int v);
        if (v < int'(DIGIT_TEN)) return CH_ZERO + CHAR_W'(v);
        return ($urandom_range(0, 1) ? CH_LA : CH_UA) + CHAR_W'(v - int'(DIGIT_TEN));
    endfunction

    // Builds and sends one random string, and returns how many of its
    // characters count as stimulus. Trailing characters after the end are
    // not counted.
    task automatic send_random_string(output int counted);
        logic [CHAR_W-1:0] text[$];
        logic [BASE_W-1:0] b;
        int                pick;
        int                radix;
        int                n_digits;
        int                n_tail;
        text = {};
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            // Noise: random bytes under a random base.
            b = BASE_W'($urandom_range(0, 36));
            repeat ($urandom_range(1, 6)) text.push_back(CHAR_W'($urandom_range(0, 255)));
            n_tail = 0;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 30) b = BASE_AUTO;
            else if (pick < 45) b = BASE_HEX;
            else if (pick < 55) b = BASE_DEC;
            else if (pick < 62) b = BASE_OCT;
            else if (pick < 92) b = BASE_W'($urandom_range(2, 36));
            else if (pick < 96) b = BASE_ONE;
            else b = BASE_W'($urandom_range(37, 63));
            repeat ($urandom_range(0, 3)) text.push_back(random_blank());
            radix = (b == BASE_AUTO) ? int'(BASE_DEC) : int'(b);
            if (b == BASE_AUTO || b == BASE_HEX) begin
                pick = $urandom_range(0, 2);
                if (pick >= 1) begin
                    text.push_back(CH_ZERO);
                    if (b == BASE_AUTO) radix = int'(BASE_OCT);
                end
                if (pick == 2) begin
                    text.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
                    radix = int'(BASE_HEX);
                end
            end
            // Invalid bases still carry digits so that they are seen to
            // be rejected.
            if (radix < 2 || radix > int'(BASE_MAX)) radix = int'(BASE_DEC);
            // Long strings in a high base make the accumulator wrap.
            n_digits = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 30) : $urandom_range(0, 12);
            repeat (n_digits) text.push_back(digit_char($urandom_range(0, radix - 1)));
            // A string is sometimes cut short by the next start.
            if ($urandom_range(0, 6) != 0)
                text.push_back($urandom_range(0, 2) == 0 ? CH_NUL : CHAR_W'($urandom_range(0, 255)));
            n_tail = $urandom_range(0, 2);
        end
        counted = text.size();
        for (int i = 0; i < text.size(); i++) begin
            if (i == 0) send_char(1'b1, b, text[i], 1'b0, NO_PIN);
            else send_plain(text[i]);
        end
        repeat (n_tail) send_plain(CHAR_W'($urandom_range(0, 255)));
    endtask

    initial begin : stimulus
        int sent;
        int got_count;
        int strings;
        directed_rows = '{
            // No start since reset: the base is detected, and characters
            // after the end repeat the held result.
            '{1'b0, BASE_AUTO, "5",     1'b1, '{32'd5, 1'b0, 16'd1}},
            '{1'b0, BASE_AUTO, CH_NUL,  1'b1, '{32'd5, 1'b1, 16'd1}},
            '{1'b0, BASE_AUTO, "9",     1'b1, '{32'd5, 1'b0, 16'd1}},
            // Whitespace, then a hex prefix and digits of both cases.
            '{1'b1, BASE_AUTO, CH_SPACE, 1'b0, NO_PIN},
            '{1'b0, BASE_AUTO, CH_TAB,  1'b0, NO_PIN},
            '{1'b0, BASE_AUTO, CH_CR,   1'b0, NO_PIN},
            '{1'b0, BASE_AUTO, CH_ZERO, 1'b0, NO_PIN},
            '{1'b0, BASE_AUTO, CH_LX,   1'b0, NO_PIN},
            '{1'b0, BASE_AUTO, "F",     1'b0, NO_PIN},
            '{1'b0, BASE_AUTO, "f",     1'b0, NO_PIN},
            '{1'b0, BASE_AUTO, "g",     1'b1, '{32'd255, 1'b1, 16'd7}},
            // A hex prefix with no hex digit behind it ends after the zero.
            '{1'b1, BASE_HEX,  CH_ZERO, 1'b0, NO_PIN},
            '{1'b0, BASE_HEX,  CH_UX,   1'b0, NO_PIN},
            '{1'b0, BASE_HEX,  "z",     1'b1, '{32'd0, 1'b1, 16'd1}},
            // A leading zero selects octal, where 8 is not a digit.
            '{1'b1, BASE_AUTO, CH_ZERO, 1'b0, NO_PIN},
            '{1'b0, BASE_AUTO, "7",     1'b0, NO_PIN},
            '{1'b0, BASE_AUTO, "8",     1'b1, '{32'd7, 1'b1, 16'd2}},
            // The largest base, with the top letter in both cases.
            '{1'b1, BASE_MAX,  "Z",     1'b1, '{32'd35, 1'b0, 16'd1}},
            '{1'b0, BASE_MAX,  "z",     1'b0, NO_PIN},
            '{1'b0, BASE_MAX,  CH_TOP,  1'b1, '{32'd1295, 1'b1, 16'd2}},
            // Invalid bases end at the first non-blank character.
            '{1'b1, BASE_ONE,  CH_SPACE, 1'b0, NO_PIN},
            '{1'b0, BASE_ONE,  "1",     1'b1, '{32'd0, 1'b1, 16'd0}},
            '{1'b1, 6'h3F,     "A",     1'b1, '{32'd0, 1'b1, 16'd0}},
            // A string with no digits at all.
            '{1'b1, BASE_DEC,  CH_DASH, 1'b1, '{32'd0, 1'b1, 16'd0}},
            // The smallest base.
            '{1'b1, 6'd2,      "1",     1'b0, NO_PIN},
            '{1'b0, 6'd2,      "2",     1'b1, '{32'd1, 1'b1, 16'd1}}
        };

        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[i]) begin
            send_char(directed_rows[i].opens, directed_rows[i].base, directed_rows[i].ch,
                      directed_rows[i].pinned, directed_rows[i].want);
        end

        sent = 0;
        strings = 0;
        while (sent < RANDOM_ITEMS) begin
            send_random_string(got_count);
            sent += got_count;
            strings++;
            // Hold off the receiver twice while characters keep coming.
            if (strings == 15 || strings == 90) hold_request = 1'b1;
            // Pause the sender once until the parser has emptied.
            if (strings == 40) drain_results();
        end

        drain_results();
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (awaited_results.size() != 0)
            report_mismatch("results never delivered", awaited_results.size(), 0);

        if (mismatch_count == 0) begin
            $display("** text_to_unsigned_integer_parser: PASSED **");
        end else begin
            $display("** text_to_unsigned_integer_parser: FAILED **");
        end
        $finish;
    end

endmodule
